FILE: design/aabb_overlap_pair_finder_unit_assert.svh
// Assertion macros shared by the overlap pair finder modules.
`ifndef AABB_OVERLAP_PAIR_FINDER_UNIT_ASSERT_SVH
`define AABB_OVERLAP_PAIR_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define AOPF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define AOPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AOPF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define AOPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/aopf_pkg.sv
// Types and constants shared by the overlap pair finder modules.
`timescale 1ns / 1ps

package aopf_pkg;

    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int KIND_W   = 2;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    // Field offsets in s_tdata
    localparam int SLOT_LSB   = 0;
    localparam int LEFT_LSB   = SLOT_LSB + SLOT_W;
    localparam int RIGHT_LSB  = LEFT_LSB + FIELD_W;
    localparam int TOP_LSB    = RIGHT_LSB + FIELD_W;
    localparam int BOTTOM_LSB = TOP_LSB + FIELD_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QFETCH,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PUSH_ACK,
        PUSH_PEND,
        PUSH_FINAL
    } push_sel_t;

    typedef struct packed {
        logic      take_item;
        logic      fetch_query;
        logic      scan_first;
        logic      advance;
        logic      take_pend;
        logic      push;
        push_sel_t push_sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic query_ok;
        logic hit;
        logic pend_valid;
        logic cand_last;
    } status_t;

endpackage

FILE: design/aopf_ctrl.sv
// Sequencer for item intake, query scan and result delivery.
`timescale 1ns / 1ps
`include "aabb_overlap_pair_finder_unit_assert.svh"

module aopf_ctrl
    import aopf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  kind_t   kind,
    input  status_t status,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   stall;

    assign accept = s_tvalid && s_tready;
    // A second hit cannot park while the older one still waits for the output
    assign stall  = status.hit && status.pend_valid && !status.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (kind == KIND_QUERY)) begin
                    state_next = ST_QFETCH;
                end
            end
            ST_QFETCH: begin
                state_next = status.query_ok ? ST_SCAN : ST_FLUSH;
            end
            ST_SCAN: begin
                if (!stall && status.cand_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        cmd.push_sel = PUSH_ACK;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = status.out_free;
                cmd.take_item = accept;
                if (accept && (kind != KIND_QUERY)) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_ACK;
                end
            end
            ST_QFETCH: begin
                cmd.fetch_query = 1'b1;
                cmd.scan_first  = 1'b1;
            end
            ST_SCAN: begin
                if (!stall) begin
                    cmd.take_pend = status.hit;
                    cmd.advance   = !status.cand_last;
                    if (status.hit && status.pend_valid) begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = PUSH_PEND;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_FINAL;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `AOPF_ASSERT_IMPL(a_push_needs_room, aclk, aresetn, cmd.push, status.out_free, "result pushed into a full output register")
    `AOPF_ASSERT_NEXT(a_query_fetches, aclk, aresetn, (accept && (kind == KIND_QUERY)), (state_reg == ST_QFETCH), "query not followed by box fetch")
    `AOPF_ASSERT_IMPL(a_ack_same_cycle, aclk, aresetn, (accept && (kind != KIND_QUERY)), (cmd.push && (cmd.push_sel == PUSH_ACK)), "non-query item without acknowledge")
    `AOPF_ASSERT_NEXT(a_flush_waits, aclk, aresetn, ((state_reg == ST_FLUSH) && !status.out_free), (state_reg == ST_FLUSH), "final result dropped")

endmodule

FILE: design/aopf_dpath.sv
// Box table, occupancy flags, overlap test and result register.
`timescale 1ns / 1ps

module aopf_dpath
    import aopf_pkg::*;
#(
    parameter int MAX_BOXES  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    input  kind_t                 kind,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [FIELD_W-1:0]    left_edge,
    input  logic [FIELD_W-1:0]    right_edge,
    input  logic [FIELD_W-1:0]    top_edge,
    input  logic [FIELD_W-1:0]    bottom_edge,
    input  logic                  m_tready,
    output status_t               status,
    output logic                  m_tvalid,
    output logic [SLOT_W-1:0]     partner,
    output logic                  found,
    output logic                  last
);

    // Only slots the 4-bit field can name are stored
    localparam int DEPTH = (MAX_BOXES < (1 << SLOT_W)) ? MAX_BOXES : (1 << SLOT_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] left;
    } box_t;

    box_t               mem [DEPTH];
    box_t               rd_data_reg;
    box_t               qbox_reg;
    box_t               wr_box;
    logic [DEPTH-1:0]   occ_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   cand_idx_reg;
    logic [IDX_W-1:0]   qslot_reg;
    logic               qin_reg;
    logic [IDX_W-1:0]   pend_reg;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [SLOT_W-1:0]  partner_reg;
    logic [SLOT_W-1:0]  partner_next;
    logic               found_reg;
    logic               found_next;
    logic               last_reg;
    logic               last_next;
    logic               in_table;
    logic [IDX_W-1:0]   slot_idx;
    logic               out_free;
    logic               rd_box_valid;
    logic               overlap;
    logic               owned;

    assign in_table = ({1'b0, slot} < (SLOT_W + 1)'(DEPTH));
    assign slot_idx = slot[IDX_W-1:0];

    assign wr_box.left   = COORD_BITS'($signed(left_edge));
    assign wr_box.right  = COORD_BITS'($signed(right_edge));
    assign wr_box.top    = COORD_BITS'($signed(top_edge));
    assign wr_box.bottom = COORD_BITS'($signed(bottom_edge));

    always_comb begin
        if (cmd.take_item) begin
            rd_addr = slot_idx;
        end else if (cmd.scan_first) begin
            rd_addr = '0;
        end else if (cmd.advance) begin
            rd_addr = IDX_W'(cand_idx_reg + 1'b1);
        end else begin
            rd_addr = cand_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item && (kind == KIND_LOAD) && in_table) begin
            mem[slot_idx] <= wr_box;
        end
        rd_data_reg  <= mem[rd_addr];
        cand_idx_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.take_item) begin
            case (kind)
                KIND_LOAD: begin
                    if (in_table) begin
                        occ_reg[slot_idx] <= 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    if (in_table) begin
                        occ_reg[slot_idx] <= 1'b0;
                    end
                end
                KIND_CLEAR: begin
                    occ_reg <= '0;
                end
                default: begin
                    occ_reg <= occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            qslot_reg <= slot_idx;
            qin_reg   <= in_table;
        end
        if (cmd.fetch_query) begin
            qbox_reg <= rd_data_reg;
        end
        if (cmd.take_pend) begin
            pend_reg <= cand_idx_reg;
        end
    end

    // An inverted box is empty and never overlaps
    assign rd_box_valid = ($signed(rd_data_reg.left) <= $signed(rd_data_reg.right)) &&
                          ($signed(rd_data_reg.top) <= $signed(rd_data_reg.bottom));

    assign overlap = ($signed(qbox_reg.left) < $signed(rd_data_reg.right)) &&
                     ($signed(rd_data_reg.left) < $signed(qbox_reg.right)) &&
                     ($signed(qbox_reg.top) < $signed(rd_data_reg.bottom)) &&
                     ($signed(rd_data_reg.top) < $signed(qbox_reg.bottom));

    // Smaller top owns the pair, ties go to the lower slot
    assign owned = ($signed(qbox_reg.top) < $signed(rd_data_reg.top)) ||
                   ((qbox_reg.top == rd_data_reg.top) && (qslot_reg < cand_idx_reg));

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        status.out_free   = out_free;
        status.query_ok   = qin_reg && occ_reg[qslot_reg] && rd_box_valid;
        status.hit        = occ_reg[cand_idx_reg] && (cand_idx_reg != qslot_reg) &&
                            rd_box_valid && overlap && owned;
        status.pend_valid = pend_valid_reg;
        status.cand_last  = (cand_idx_reg == IDX_W'(DEPTH - 1));
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (cmd.take_item) begin
            pend_valid_next = 1'b0;
        end else if (cmd.take_pend) begin
            pend_valid_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        partner_next = partner_reg;
        found_next   = found_reg;
        last_next    = last_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
            case (cmd.push_sel)
                PUSH_ACK: begin
                    partner_next = '0;
                    found_next   = 1'b0;
                    last_next    = 1'b1;
                end
                PUSH_PEND: begin
                    partner_next = SLOT_W'(pend_reg);
                    found_next   = 1'b1;
                    last_next    = 1'b0;
                end
                PUSH_FINAL: begin
                    partner_next = pend_valid_reg ? SLOT_W'(pend_reg) : '0;
                    found_next   = pend_valid_reg;
                    last_next    = 1'b1;
                end
                default: begin
                    partner_next = '0;
                    found_next   = 1'b0;
                    last_next    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        partner_reg <= partner_next;
        found_reg   <= found_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign partner  = partner_reg;
    assign found    = found_reg;
    assign last     = last_reg;

endmodule

FILE: design/aabb_overlap_pair_finder_unit.sv
// Top level of the 2D box overlap pair finder.
`timescale 1ns / 1ps

// Keeps a table of axis-aligned boxes by slot and answers one item at a time.
// Load, remove and clear items return a single acknowledge item (found 0,
// last 1). A query item first fetches the queried box, then sweeps the stored
// table one slot per cycle (held while the result side stalls) through the
// single read port of the box memory, and reports every occupied box that
// overlaps it strictly on both axes and that it owns (smaller top edge, ties
// to the lower slot), in ascending slot order; a query with no partner returns
// the acknowledge item. A query of a free, empty or out-of-table slot skips
// the sweep. The next item is taken once the final result is registered and
// the output register can take another item.
// Touching edges do not overlap, an inverted box is empty, and a slot beyond
// the table is ignored. Coordinates are held in COORD_BITS-bit two's complement.
// Box storage is undefined until loaded; occupancy flags clear at reset.

module aabb_overlap_pair_finder_unit
    import aopf_pkg::*;
#(
    parameter int MAX_BOXES  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] slot, [19:4] left_edge, [35:20] right_edge, [51:36] top_edge,
    // [67:52] bottom_edge, [71:68] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_tuser,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] partner, [7:4] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    // [0] found
    output logic [0:0]            m_tuser,
    output logic                  m_tlast
);

    cmd_t              cmd;
    status_t           status;
    kind_t             kind;
    logic [SLOT_W-1:0] partner;
    logic              found;

    // Decode the item kind once for both halves
    assign kind = kind_t'(s_tuser);

    aopf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .kind     (kind),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    aopf_dpath #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .kind        (kind),
        .slot        (s_tdata[SLOT_LSB +: SLOT_W]),
        .left_edge   (s_tdata[LEFT_LSB +: FIELD_W]),
        .right_edge  (s_tdata[RIGHT_LSB +: FIELD_W]),
        .top_edge    (s_tdata[TOP_LSB +: FIELD_W]),
        .bottom_edge (s_tdata[BOTTOM_LSB +: FIELD_W]),
        .m_tready    (m_tready),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .partner     (partner),
        .found       (found),
        .last        (m_tlast)
    );

    // Pad the partner slot up to a whole byte
    assign m_tdata    = M_DATA_W'(partner);
    assign m_tuser[0] = found;

endmodule
